[hdl/trzb_pkg.sv]
// Package for the triangle rasterizer with depth store.
// Holds item types, request codes, sequencer states and small helpers.
// No dependencies.
package trzb_pkg;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_DRAW  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam int COORD_W = 12;
   localparam int DEPTH_W = 24;
   localparam int COLOR_W = 24;
   localparam int COUNT_W = 17;
   localparam int PIX_W   = 8;   // pixel coordinate after >>4 of a 12-bit value
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = 51;
   localparam int EDGE_W  = 26;
   localparam int BARY_W  = 25;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [COORD_W-1:0]  v0_x;
      logic [COORD_W-1:0]  v0_y;
      logic [DEPTH_W-1:0]  v0_z;
      logic [COORD_W-1:0]  v1_x;
      logic [COORD_W-1:0]  v1_y;
      logic [DEPTH_W-1:0]  v1_z;
      logic [COORD_W-1:0]  v2_x;
      logic [COORD_W-1:0]  v2_y;
      logic [DEPTH_W-1:0]  v2_z;
      logic [COLOR_W-1:0]  fill_color;
      logic [15:0]         pixel_index;
   } req_item_type;

   typedef struct packed {
      logic                status;
      logic [COLOR_W-1:0]  read_color;
      logic [DEPTH_W-1:0]  read_depth;
      logic [COUNT_W-1:0]  pixels_written;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AREA,
      ST_BASE,
      ST_EDGE,
      ST_INSIDE,
      ST_WZ,
      ST_DIV,
      ST_TEST,
      ST_NEXT,
      ST_READ,
      ST_FINISH
   } state_type;

   // signed difference of two unsigned 12-bit coordinates
   function automatic logic signed [COORD_W:0] diff13(logic [COORD_W-1:0] p,
                                                     logic [COORD_W-1:0] q);
      diff13 = $signed({1'b0, p}) - $signed({1'b0, q});
   endfunction

endpackage

[hdl/trzb_chan_if.sv]
// Valid/ready channel interfaces for request and response items.
// Depends on trzb_pkg for the payload types.
interface trzb_req_if;
   logic                       valid;
   logic                       ready;
   trzb_pkg::req_item_type     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface trzb_rsp_if;
   logic                       valid;
   logic                       ready;
   trzb_pkg::rsp_item_type     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/triangle_raster_zbuffer_top.sv]
// Triangle rasterizer with depth and color stores, one shared multiplier.
// Clear: one store entry per cycle.
// Draw: setup, then an edge test for each pixel of the bounding box; covered pixels
// also get an interpolated depth (multiplier and 24-step divider) and a depth test.
// Read: a registered store read. One item at a time; a result register holds the last item.
// Reset: synchronous; a clearing pass over all W*H entries runs before the first item.
module triangle_raster_zbuffer_top #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 256
) (
   input  logic             clock,
   input  logic             reset,
   trzb_req_if.sink         req_ch,
   trzb_rsp_if.source       rsp_ch
);

   localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW  = $clog2(PIX);

   // ---------------------------------------------------------------- stores
   logic [trzb_pkg::DEPTH_W-1:0] depth_mem [PIX];
   logic [trzb_pkg::COLOR_W-1:0] color_mem [PIX];

   // ---------------------------------------------------------------- state
   trzb_pkg::state_type state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        have_req_ff, have_req_in;
   logic [AW-1:0] clr_ff, clr_in;

   // latched request
   logic [1:0]                    type_ff;
   logic [trzb_pkg::COORD_W-1:0]  vx_ff [3];
   logic [trzb_pkg::COORD_W-1:0]  vy_ff [3];
   logic [trzb_pkg::DEPTH_W-1:0]  vz_ff [3];
   logic [trzb_pkg::COLOR_W-1:0]  color_ff;
   logic [15:0]                   pidx_ff;

   // draw datapath
   logic signed [trzb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [trzb_pkg::PROD_W-1:0]  tmp_ff, tmp_in;
   logic signed [trzb_pkg::EDGE_W-1:0]  w_ff [3];
   logic signed [trzb_pkg::EDGE_W-1:0]  w_in [3];
   logic [trzb_pkg::BARY_W-1:0]         wa_ff [3];
   logic [trzb_pkg::BARY_W-1:0]         wa_in [3];
   logic                                neg_ff, neg_in;
   logic [trzb_pkg::BARY_W-1:0]         area_ff, area_in;
   logic [trzb_pkg::PIX_W-1:0]          xmin_ff, xmin_in, xmax_ff, xmax_in;
   logic [trzb_pkg::PIX_W-1:0]          ymax_ff, ymax_in;
   logic [trzb_pkg::PIX_W-1:0]          px_ff, px_in, py_ff, py_in;
   logic [AW-1:0]                       row_ff, row_in;
   logic [trzb_pkg::PROD_W-1:0]         num_ff, num_in;
   logic [trzb_pkg::BARY_W-1:0]         rem_ff, rem_in;
   logic [trzb_pkg::DEPTH_W-1:0]        lo_ff, lo_in;
   logic [trzb_pkg::DEPTH_W-1:0]        q_ff, q_in;
   logic                                degen_ff, degen_in;
   logic [trzb_pkg::COUNT_W-1:0]        count_ff, count_in;

   // memory port
   logic [AW-1:0]                 raddr, waddr;
   logic                          wen;
   logic [trzb_pkg::DEPTH_W-1:0]  wdepth;
   logic [trzb_pkg::COLOR_W-1:0]  wcolor;
   logic [trzb_pkg::DEPTH_W-1:0]  rd_depth_ff;
   logic [trzb_pkg::COLOR_W-1:0]  rd_color_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   trzb_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // shared multiplier operands
   logic signed [trzb_pkg::MUL_A_W-1:0] mul_a;
   logic signed [trzb_pkg::MUL_B_W-1:0] mul_b;

   logic req_fire;
   assign req_ch.ready = (state_ff == trzb_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // pixel address of the current scan position
   logic [AW-1:0] pix_addr;
   logic [31:0]   pidx32;
   logic          pidx_ok;
   assign pix_addr = row_ff + AW'(px_ff);
   assign pidx32   = 32'(pidx_ff);
   assign pidx_ok  = pidx32 < 32'(PIX);
   assign raddr    = (type_ff == trzb_pkg::REQ_READ) ? pidx32[AW-1:0] : pix_addr;

   // edge vertex pair for the current step: edge k runs from (k+1)%3 to (k+2)%3
   logic [1:0] ek, ea, eb;
   assign ek = step_ff[2:1];
   always_comb begin
      case (ek)
         2'd0: begin ea = 2'd1; eb = 2'd2; end
         2'd1: begin ea = 2'd2; eb = 2'd0; end
         default: begin ea = 2'd0; eb = 2'd1; end
      endcase
   end

   logic [trzb_pkg::COORD_W-1:0] sx, sy;
   assign sx = {px_ff, 4'b0000};
   assign sy = {py_ff, 4'b0000};

   // bounding box from the latched vertices
   logic [trzb_pkg::COORD_W-1:0] mnx, mny, mxx, mxy, t0, t1;
   logic [10:0] xmax_c, ymax_c;
   always_comb begin
      t0  = (vx_ff[0] < vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      mnx = (t0 < vx_ff[2]) ? t0 : vx_ff[2];
      t1  = (vy_ff[0] < vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      mny = (t1 < vy_ff[2]) ? t1 : vy_ff[2];
      mxx = (vx_ff[0] > vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      mxx = (mxx > vx_ff[2]) ? mxx : vx_ff[2];
      mxy = (vy_ff[0] > vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      mxy = (mxy > vy_ff[2]) ? mxy : vy_ff[2];
      xmax_c = ({3'b000, mxx[11:4]} > 11'(SCREEN_WIDTH - 1)) ?
               11'(SCREEN_WIDTH - 1) : {3'b000, mxx[11:4]};
      ymax_c = ({3'b000, mxy[11:4]} > 11'(SCREEN_HEIGHT - 1)) ?
               11'(SCREEN_HEIGHT - 1) : {3'b000, mxy[11:4]};
   end

   logic signed [trzb_pkg::PROD_W-1:0] area_s;
   logic box_empty;
   assign area_s    = tmp_ff - prod_ff;
   assign box_empty = ({3'b000, mnx[11:4]} > xmax_c) || ({3'b000, mny[11:4]} > ymax_c);

   // inside test on sign-adjusted edge values
   logic signed [trzb_pkg::EDGE_W-1:0] adj [3];
   logic covered;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         adj[k] = neg_ff ? -w_ff[k] : w_ff[k];
      end
      covered = !adj[0][trzb_pkg::EDGE_W-1] && !adj[1][trzb_pkg::EDGE_W-1] &&
                !adj[2][trzb_pkg::EDGE_W-1];
   end

   // divider step: shift in one dividend bit, subtract when it fits
   logic [trzb_pkg::BARY_W:0] dshift, dsub;
   logic dge;
   assign dshift = {rem_ff, lo_ff[trzb_pkg::DEPTH_W-1]};
   assign dge    = dshift >= {1'b0, area_ff};
   assign dsub   = dshift - {1'b0, area_ff};

   logic [trzb_pkg::PROD_W-1:0] num_total;
   assign num_total = num_ff + trzb_pkg::PROD_W'(prod_ff);

   logic last_col, last_row;
   assign last_col = (px_ff == xmax_ff);
   assign last_row = (py_ff == ymax_ff);

   // ------------------------------------------------------- multiplier mux
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         trzb_pkg::ST_AREA: begin
            if (step_ff == 5'd0) begin
               mul_a = trzb_pkg::MUL_A_W'(trzb_pkg::diff13(vx_ff[1], vx_ff[0]));
               mul_b = trzb_pkg::MUL_B_W'(trzb_pkg::diff13(vy_ff[2], vy_ff[0]));
            end else begin
               mul_a = trzb_pkg::MUL_A_W'(trzb_pkg::diff13(vy_ff[1], vy_ff[0]));
               mul_b = trzb_pkg::MUL_B_W'(trzb_pkg::diff13(vx_ff[2], vx_ff[0]));
            end
         end
         trzb_pkg::ST_BASE: begin
            mul_a = $signed(trzb_pkg::MUL_A_W'(SCREEN_HEIGHT - 1)) -
                    $signed({{(trzb_pkg::MUL_A_W-trzb_pkg::PIX_W){1'b0}}, py_ff});
            mul_b = $signed(trzb_pkg::MUL_B_W'(SCREEN_WIDTH));
         end
         trzb_pkg::ST_EDGE: begin
            if (!step_ff[0]) begin
               mul_a = trzb_pkg::MUL_A_W'(trzb_pkg::diff13(vx_ff[eb], vx_ff[ea]));
               mul_b = trzb_pkg::MUL_B_W'(trzb_pkg::diff13(sy, vy_ff[ea]));
            end else begin
               mul_a = trzb_pkg::MUL_A_W'(trzb_pkg::diff13(vy_ff[eb], vy_ff[ea]));
               mul_b = trzb_pkg::MUL_B_W'(trzb_pkg::diff13(sx, vx_ff[ea]));
            end
         end
         trzb_pkg::ST_WZ: begin
            if (step_ff[1:0] != 2'd3) begin
               mul_a = $signed({1'b0, wa_ff[step_ff[1:0]]});
               mul_b = $signed({1'b0, vz_ff[step_ff[1:0]]});
            end
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // ------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trzb_pkg::ST_CLEAR:
            if (clr_ff == AW'(PIX - 1))
               state_in = have_req_ff ? trzb_pkg::ST_FINISH : trzb_pkg::ST_IDLE;
         trzb_pkg::ST_IDLE:
            if (req_fire) begin
               case (req_ch.data.req_type)
                  trzb_pkg::REQ_CLEAR: state_in = trzb_pkg::ST_CLEAR;
                  trzb_pkg::REQ_DRAW:  state_in = trzb_pkg::ST_AREA;
                  trzb_pkg::REQ_READ:  state_in = trzb_pkg::ST_READ;
                  default:             state_in = trzb_pkg::ST_FINISH;
               endcase
            end
         trzb_pkg::ST_AREA:
            if (step_ff == 5'd2)
               state_in = (area_s == '0 || box_empty) ? trzb_pkg::ST_FINISH
                                                       : trzb_pkg::ST_BASE;
         trzb_pkg::ST_BASE:
            if (step_ff == 5'd1) state_in = trzb_pkg::ST_EDGE;
         trzb_pkg::ST_EDGE:
            if (step_ff == 5'd6) state_in = trzb_pkg::ST_INSIDE;
         trzb_pkg::ST_INSIDE:
            state_in = covered ? trzb_pkg::ST_WZ : trzb_pkg::ST_NEXT;
         trzb_pkg::ST_WZ:
            if (step_ff == 5'd3) state_in = trzb_pkg::ST_DIV;
         trzb_pkg::ST_DIV:
            if (step_ff == 5'd23) state_in = trzb_pkg::ST_TEST;
         trzb_pkg::ST_TEST:
            state_in = trzb_pkg::ST_NEXT;
         trzb_pkg::ST_NEXT:
            state_in = (last_col && last_row) ? trzb_pkg::ST_FINISH : trzb_pkg::ST_EDGE;
         trzb_pkg::ST_READ:
            state_in = trzb_pkg::ST_FINISH;
         trzb_pkg::ST_FINISH:
            if (!rsp_valid_ff || rsp_ch.ready) state_in = trzb_pkg::ST_IDLE;
         default:
            state_in = trzb_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------- datapath
   always_comb begin
      step_in     = step_ff + 5'd1;
      have_req_in = have_req_ff;
      clr_in      = clr_ff;
      tmp_in      = tmp_ff;
      w_in        = w_ff;
      wa_in       = wa_ff;
      neg_in      = neg_ff;
      area_in     = area_ff;
      xmin_in     = xmin_ff;
      xmax_in     = xmax_ff;
      ymax_in     = ymax_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      row_in      = row_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      lo_in       = lo_ff;
      q_in        = q_ff;
      degen_in    = degen_ff;
      count_in    = count_ff;
      wen         = 1'b0;
      waddr       = pix_addr;
      wdepth      = q_ff;
      wcolor      = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         trzb_pkg::ST_CLEAR: begin
            // sweep: farthest depth, black
            wen    = 1'b1;
            waddr  = clr_ff;
            wdepth = '1;
            wcolor = '0;
            clr_in = clr_ff + AW'(1);
         end
         trzb_pkg::ST_IDLE: begin
            step_in = '0;
            clr_in  = '0;
            if (req_fire) begin
               have_req_in = 1'b1;
               degen_in    = 1'b0;
               count_in    = '0;
            end
         end
         trzb_pkg::ST_AREA: begin
            if (step_ff == 5'd1) tmp_in = prod_ff;
            if (step_ff == 5'd2) begin
               step_in  = '0;
               degen_in = (area_s == '0);
               neg_in   = area_s[trzb_pkg::PROD_W-1];
               area_in  = area_s[trzb_pkg::PROD_W-1] ? trzb_pkg::BARY_W'(-area_s)
                                                     : trzb_pkg::BARY_W'(area_s);
               xmin_in  = mnx[11:4];
               xmax_in  = xmax_c[trzb_pkg::PIX_W-1:0];
               ymax_in  = ymax_c[trzb_pkg::PIX_W-1:0];
               px_in    = mnx[11:4];
               py_in    = mny[11:4];
            end
         end
         trzb_pkg::ST_BASE: begin
            if (step_ff == 5'd1) begin
               row_in  = prod_ff[AW-1:0];
               step_in = '0;
            end
         end
         trzb_pkg::ST_EDGE: begin
            // odd steps hold the first product, even steps close an edge
            if (step_ff[0]) tmp_in = prod_ff;
            else if (step_ff != 5'd0)
               w_in[step_ff[2:1] - 2'd1] = trzb_pkg::EDGE_W'(tmp_ff - prod_ff);
            if (step_ff == 5'd6) step_in = '0;
         end
         trzb_pkg::ST_INSIDE: begin
            step_in = '0;
            num_in  = '0;
            for (int k = 0; k < 3; k++) wa_in[k] = adj[k][trzb_pkg::BARY_W-1:0];
         end
         trzb_pkg::ST_WZ: begin
            if (step_ff != 5'd0) num_in = num_total;
            if (step_ff == 5'd3) begin
               // quotient fits 24 bits, so the upper part is below the divisor
               rem_in  = num_total[trzb_pkg::DEPTH_W +: trzb_pkg::BARY_W];
               lo_in   = num_total[trzb_pkg::DEPTH_W-1:0];
               step_in = '0;
            end
         end
         trzb_pkg::ST_DIV: begin
            rem_in = dge ? dsub[trzb_pkg::BARY_W-1:0] : dshift[trzb_pkg::BARY_W-1:0];
            lo_in  = {lo_ff[trzb_pkg::DEPTH_W-2:0], 1'b0};
            q_in   = {q_ff[trzb_pkg::DEPTH_W-2:0], dge};
         end
         trzb_pkg::ST_TEST: begin
            // strictly nearer wins
            if (q_ff < rd_depth_ff) begin
               wen      = 1'b1;
               count_in = count_ff + trzb_pkg::COUNT_W'(1);
            end
         end
         trzb_pkg::ST_NEXT: begin
            step_in = '0;
            if (last_col) begin
               px_in  = xmin_ff;
               py_in  = py_ff + trzb_pkg::PIX_W'(1);
               row_in = row_ff - AW'(SCREEN_WIDTH);
            end else begin
               px_in = px_ff + trzb_pkg::PIX_W'(1);
            end
         end
         trzb_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               have_req_in  = 1'b0;
               rsp_data_in.status         = degen_ff;
               rsp_data_in.pixels_written = count_ff;
               if (type_ff == trzb_pkg::REQ_READ && pidx_ok) begin
                  rsp_data_in.read_color = rd_color_ff;
                  rsp_data_in.read_depth = rd_depth_ff;
               end else begin
                  rsp_data_in.read_color = '0;
                  rsp_data_in.read_depth = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trzb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         have_req_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         have_req_ff  <= have_req_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff  <= req_ch.data.req_type;
         vx_ff[0] <= req_ch.data.v0_x;
         vy_ff[0] <= req_ch.data.v0_y;
         vz_ff[0] <= req_ch.data.v0_z;
         vx_ff[1] <= req_ch.data.v1_x;
         vy_ff[1] <= req_ch.data.v1_y;
         vz_ff[1] <= req_ch.data.v1_z;
         vx_ff[2] <= req_ch.data.v2_x;
         vy_ff[2] <= req_ch.data.v2_y;
         vz_ff[2] <= req_ch.data.v2_z;
         color_ff <= req_ch.data.fill_color;
         pidx_ff  <= req_ch.data.pixel_index;
      end
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
      w_ff        <= w_in;
      wa_ff       <= wa_in;
      neg_ff      <= neg_in;
      area_ff     <= area_in;
      xmin_ff     <= xmin_in;
      xmax_ff     <= xmax_in;
      ymax_ff     <= ymax_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      row_ff      <= row_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      q_ff        <= q_in;
      degen_ff    <= degen_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // store port: one write, one registered read
   always_ff @(posedge clock) begin
      if (wen) begin
         depth_mem[waddr] <= wdepth;
         color_mem[waddr] <= wcolor;
      end
      rd_depth_ff <= depth_mem[raddr];
      rd_color_ff <= color_mem[raddr];
   end

   // ------------------------------------------------------- assertions
   a_div_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trzb_pkg::ST_DIV) |-> (rem_ff < area_ff))
      else $error("divider remainder reached the divisor");

   a_degen_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status |-> (rsp_data_ff.pixels_written == '0))
      else $error("degenerate triangle reported written pixels");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trzb_pkg::ST_CLEAR) |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

endmodule
